@@ rtl/core/glc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lunar calendar package
// Table of lunar year layouts, month start offsets and sizes that the
// Gregorian to lunar date converter shares.
// ----------------------------------------------------------------------------
`default_nettype none

package glc_pkg;

  localparam int unsigned ROM_ROWS   = 199;
  localparam int unsigned FIRST_YEAR = 1901;

  localparam int unsigned YEAR_W = 12;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned ROW_W  = 8;
  localparam int unsigned DOY_W  = 9;

  localparam logic [MON_W-1:0] LAST_TABLE_MONTH = 4'd13;
  localparam logic [MON_W-1:0] LAST_MONTH       = 4'd12;
  localparam logic [4:0]       SHORT_LEN        = 5'd29;
  localparam logic [4:0]       LONG_LEN         = 5'd30;

  typedef logic [23:0] rom_row_t;

  // Byte 0: leap month and flags of table months 1-4. Byte 1: flags of
  // months 5-12. Byte 2: flag of month 13 and the Spring Festival date.
  localparam rom_row_t LUNAR_ROM [ROM_ROWS] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
    24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
    24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
    24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
    24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
    24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
    24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
    24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
    24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
    24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
    24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
    24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h7AD53C,
    24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
    24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
    24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
    24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
    24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
    24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
    24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
    24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
    24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
    24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
    24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
    24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
    24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
    24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
    24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
    24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
    24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
    24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
    24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
    24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
    24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
    24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
    24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
    24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
    24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
    24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  // Days from January 1 to the first of each month in a common year.
  localparam logic [DOY_W-1:0] MONTH_START [12] = '{
    9'h000, 9'h01F, 9'h03B, 9'h05A, 9'h078, 9'h097,
    9'h0B5, 9'h0D4, 9'h0F3, 9'h111, 9'h130, 9'h14E
  };

endpackage

`default_nettype wire

@@ rtl/core/gregorian_to_lunar_date.sv @@
// ----------------------------------------------------------------------------
// Gregorian to lunar date converter
// Converts a Gregorian date into the Chinese lunar year, month and day by
// walking the months of a table year one step per cycle.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | start, busy          | in_greg_year, in_greg_month, in_greg_day
//   result   | out_valid (strobe)   | out_lunar_year, out_lunar_month,
//            |                      | out_lunar_day, out_out_of_range
//
// A transaction is accepted when start is high and busy is low. A year or
// month outside the table, or a zero day, gives its result from the check
// state, and a date of the first table year before its Spring Festival from
// the Spring Festival state. Otherwise the sequencer passes the check, row
// and Spring Festival states, and the previous-year state before the Spring
// Festival, then walks up to 12 month steps, one table lookup and one subtract
// a cycle. busy is high from acceptance to the result strobe. Reset is
// synchronous and clears the sequencer and the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_to_lunar_date
  import glc_pkg::*;
#(
  parameter int unsigned TABLE_YEARS = 199
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [YEAR_W-1:0] in_greg_year,
  input  wire logic [MON_W-1:0]  in_greg_month,
  input  wire logic [DAY_W-1:0]  in_greg_day,
  output logic                   out_valid,
  output logic [YEAR_W-1:0]      out_lunar_year,
  output logic [MON_W-1:0]       out_lunar_month,
  output logic [DAY_W-1:0]       out_lunar_day,
  output logic                   out_out_of_range
);

  localparam logic [YEAR_W-1:0] YEAR_FIRST = YEAR_W'(FIRST_YEAR);
  localparam logic [YEAR_W-1:0] YEAR_END   = YEAR_W'(FIRST_YEAR + TABLE_YEARS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ROW,
    S_SF,
    S_PREV,
    S_WALK_FWD,
    S_WALK_BACK
  } state_t;

  state_t            state_r, state_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [MON_W-1:0]  gm_r, gm_nxt;
  logic [DAY_W-1:0]  gd_r, gd_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  rom_row_t          rom_r, rom_nxt;
  logic [DOY_W-1:0]  doy_r, doy_nxt;
  logic [DOY_W-1:0]  rem_r, rem_nxt;
  logic [MON_W-1:0]  leap_r, leap_nxt;
  logic [MON_W-1:0]  mon_r, mon_nxt;
  logic [MON_W-1:0]  tm_r, tm_nxt;
  logic              flag_r, flag_nxt;
  logic [YEAR_W-1:0] ly_r, ly_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0] out_year_r, out_year_nxt;
  logic [MON_W-1:0]  out_month_r, out_month_nxt;
  logic [DAY_W-1:0]  out_day_r, out_day_nxt;
  logic              out_oor_r, out_oor_nxt;

  logic [DOY_W-1:0]  sf_off;
  logic [DOY_W-1:0]  month_len;
  logic [4:0]        len_bit_idx;
  logic [MON_W-1:0]  mon_dec;
  logic [MON_W-1:0]  leap_row;

  always_comb begin
    if (rom_r[6:5] == 2'd1) begin
      sf_off = (rom_r[4:0] == 5'd0) ? '0 : DOY_W'(rom_r[4:0] - 5'd1);
    end else begin
      sf_off = DOY_W'(rom_r[4:0]) + DOY_W'(LONG_LEN);
    end
  end

  assign len_bit_idx = 5'd20 - {1'b0, tm_r};
  assign leap_row    = rom_r[23:20];

  always_comb begin
    if (tm_r >= 4'd1 && tm_r <= LAST_TABLE_MONTH && rom_r[len_bit_idx]) begin
      month_len = DOY_W'(LONG_LEN);
    end else begin
      month_len = DOY_W'(SHORT_LEN);
    end
  end

  assign mon_dec = flag_r ? mon_r : mon_r - 4'd1;

  always_comb begin
    state_nxt     = state_r;
    year_nxt      = year_r;
    gm_nxt        = gm_r;
    gd_nxt        = gd_r;
    row_nxt       = row_r;
    rom_nxt       = rom_r;
    doy_nxt       = doy_r;
    rem_nxt       = rem_r;
    leap_nxt      = leap_r;
    mon_nxt       = mon_r;
    tm_nxt        = tm_r;
    flag_nxt      = flag_r;
    ly_nxt        = ly_r;
    out_valid_nxt = 1'b0;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_oor_nxt   = out_oor_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          year_nxt  = in_greg_year;
          gm_nxt    = in_greg_month;
          gd_nxt    = in_greg_day;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (year_r < YEAR_FIRST || year_r >= YEAR_END ||
            gm_r == 4'd0 || gm_r > LAST_MONTH || gd_r == 5'd0) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = '0;
          out_month_nxt = '0;
          out_day_nxt   = '0;
          out_oor_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          row_nxt   = ROW_W'(year_r - YEAR_FIRST);
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        rom_nxt = LUNAR_ROM[row_r];
        doy_nxt = MONTH_START[gm_r - 4'd1] + DOY_W'(gd_r) - DOY_W'(1)
                  + DOY_W'(gm_r > 4'd2 && year_r[1:0] == 2'd0);
        state_nxt = S_SF;
      end
      S_SF: begin
        if (doy_r >= sf_off) begin
          rem_nxt   = doy_r - sf_off;
          leap_nxt  = leap_row;
          mon_nxt   = 4'd1;
          tm_nxt    = 4'd1;
          flag_nxt  = 1'b0;
          ly_nxt    = year_r;
          state_nxt = S_WALK_FWD;
        end else if (row_r == '0) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = '0;
          out_month_nxt = '0;
          out_day_nxt   = '0;
          out_oor_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rem_nxt   = sf_off - doy_r;
          row_nxt   = row_r - ROW_W'(1);
          ly_nxt    = year_r - YEAR_W'(1);
          state_nxt = S_PREV;
        end
      end
      S_PREV: begin
        rom_nxt   = LUNAR_ROM[row_r];
        leap_nxt  = LUNAR_ROM[row_r][23:20];
        mon_nxt   = LAST_MONTH;
        tm_nxt    = (LUNAR_ROM[row_r][23:20] == 4'd0) ? LAST_MONTH : LAST_TABLE_MONTH;
        flag_nxt  = (LUNAR_ROM[row_r][23:20] == LAST_MONTH);
        state_nxt = S_WALK_BACK;
      end
      S_WALK_FWD: begin
        if (rem_r >= month_len && tm_r < LAST_TABLE_MONTH) begin
          rem_nxt = rem_r - month_len;
          tm_nxt  = tm_r + 4'd1;
          if (mon_r == leap_r) begin
            flag_nxt = !flag_r;
            if (flag_r) begin
              mon_nxt = mon_r + 4'd1;
            end
          end else begin
            mon_nxt = mon_r + 4'd1;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = ly_r;
          out_month_nxt = mon_r;
          out_day_nxt   = DAY_W'(rem_r + DOY_W'(1));
          out_oor_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK_BACK: begin
        if (rem_r > month_len && tm_r > 4'd1) begin
          rem_nxt = rem_r - month_len;
          tm_nxt  = tm_r - 4'd1;
          mon_nxt = mon_dec;
          if (mon_dec == leap_r) begin
            flag_nxt = !flag_r;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = ly_r;
          out_month_nxt = mon_r;
          out_day_nxt   = (month_len >= rem_r) ?
                          DAY_W'(month_len - rem_r + DOY_W'(1)) : DAY_W'(1);
          out_oor_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    year_r      <= year_nxt;
    gm_r        <= gm_nxt;
    gd_r        <= gd_nxt;
    row_r       <= row_nxt;
    rom_r       <= rom_nxt;
    doy_r       <= doy_nxt;
    rem_r       <= rem_nxt;
    leap_r      <= leap_nxt;
    mon_r       <= mon_nxt;
    tm_r        <= tm_nxt;
    flag_r      <= flag_nxt;
    ly_r        <= ly_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_lunar_year   = out_year_r;
  assign out_lunar_month  = out_month_r;
  assign out_lunar_day    = out_day_r;
  assign out_out_of_range = out_oor_r;

`ifndef SYNTHESIS
  // An accepted transaction holds the converter busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not make the converter busy");

  // The result strobe comes with the sequencer back at rest.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the converter is still busy");

  // No two result strobes are back to back.
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // A date outside the table carries all-zero date fields.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_lunar_year == '0 && out_lunar_month == '0 && out_lunar_day == '0)
    else $error("out-of-range result carries a nonzero date");
`endif

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Gregorian to lunar date converter testbench
// Feeds directed edge dates and 950 random dates through the command
// interface with random gaps, predicts each lunar date from the shared table,
// and checks every result strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import glc_pkg::*;

  localparam int unsigned TABLE_YEARS = 199;
  localparam int unsigned RANDOM_DATES = 950;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    int unsigned       idle;
  } greg_date_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic              oor;
  } lunar_date_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [YEAR_W-1:0] in_greg_year = '0;
  logic [MON_W-1:0]  in_greg_month = '0;
  logic [DAY_W-1:0]  in_greg_day = '0;
  logic              out_valid;
  logic [YEAR_W-1:0] out_lunar_year;
  logic [MON_W-1:0]  out_lunar_month;
  logic [DAY_W-1:0]  out_lunar_day;
  logic              out_out_of_range;

  greg_date_t  pending_dates[$];
  lunar_date_t lunar_due[$];
  greg_date_t  cur_date;
  bit          have_date = 1'b0;
  int unsigned idle_left = 0;
  int unsigned n_dates_total = 0;
  int unsigned n_dates_sent = 0;
  int unsigned n_mismatches = 0;

  gregorian_to_lunar_date #(
    .TABLE_YEARS(TABLE_YEARS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_greg_year     (in_greg_year),
    .in_greg_month    (in_greg_month),
    .in_greg_day      (in_greg_day),
    .out_valid        (out_valid),
    .out_lunar_year   (out_lunar_year),
    .out_lunar_month  (out_lunar_month),
    .out_lunar_day    (out_lunar_day),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic lunar_date_t lunar_from_gregorian(input logic [YEAR_W-1:0] y,
                                                       input logic [MON_W-1:0] m,
                                                       input logic [DAY_W-1:0] d);
    lunar_date_t res;
    rom_row_t    ent;
    logic [7:0]  b2;
    int unsigned row, sf_off, doy, rem, leap, tm, len, mon, dd, ly;
    bit          flag;
    res = '0;
    res.oor = 1'b1;
    if (y < FIRST_YEAR || y >= FIRST_YEAR + TABLE_YEARS) return res;
    if (m < 1 || m > 12 || d == 0) return res;
    row = y - FIRST_YEAR;
    ent = LUNAR_ROM[row];
    b2 = ent[7:0];
    if (b2[6:5] == 2'd1) begin
      sf_off = (b2[4:0] == 0) ? 0 : b2[4:0] - 1;
    end else begin
      sf_off = b2[4:0] + 30;
    end
    doy = MONTH_START[m - 1] + d - 1;
    if (m > 2 && y % 4 == 0) doy++;
    if (doy >= sf_off) begin
      rem = doy - sf_off;
      leap = ent[23:20];
      mon = 1;
      tm = 1;
      flag = 1'b0;
      len = 29 + ent[20 - tm];
      while (rem >= len && tm < 13) begin
        rem -= len;
        tm++;
        if (mon == leap) begin
          flag = !flag;
          if (!flag) mon++;
        end else begin
          mon++;
        end
        len = 29 + ent[20 - tm];
      end
      dd = rem + 1;
      ly = y;
    end else begin
      if (row == 0) return res;
      rem = sf_off - doy;
      row--;
      ent = LUNAR_ROM[row];
      ly = y - 1;
      leap = ent[23:20];
      mon = 12;
      tm = (leap == 0) ? 12 : 13;
      flag = (leap == 12);
      len = 29 + ent[20 - tm];
      while (rem > len && tm > 1) begin
        rem -= len;
        tm--;
        if (!flag) mon--;
        if (mon == leap) flag = !flag;
        len = 29 + ent[20 - tm];
      end
      dd = (len >= rem) ? len - rem + 1 : 1;
    end
    res.year = ly[YEAR_W-1:0];
    res.month = mon[MON_W-1:0];
    res.day = dd[DAY_W-1:0];
    res.oor = 1'b0;
    return res;
  endfunction

  task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d,
                          input int unsigned idle);
    greg_date_t g;
    g.year = y[YEAR_W-1:0];
    g.month = m[MON_W-1:0];
    g.day = d[DAY_W-1:0];
    g.idle = idle;
    pending_dates.push_back(g);
    n_dates_total++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        lunar_due.push_back(lunar_from_gregorian(in_greg_year, in_greg_month, in_greg_day));
        n_dates_sent++;
        have_date = 1'b0;
      end
      if (!have_date && pending_dates.size() > 0) begin
        cur_date = pending_dates.pop_front();
        idle_left = cur_date.idle;
        have_date = 1'b1;
      end
      if (have_date && idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (have_date) begin
        start <= 1'b1;
        in_greg_year <= cur_date.year;
        in_greg_month <= cur_date.month;
        in_greg_day <= cur_date.day;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    lunar_date_t want;
    if (rst_n && out_valid) begin
      if (lunar_due.size() == 0) begin
        n_mismatches++;
        $display("%0t: unexpected result, actual %0d/%0d/%0d oor=%0b", $time,
                 out_lunar_year, out_lunar_month, out_lunar_day, out_out_of_range);
      end else begin
        want = lunar_due.pop_front();
        if (want.year !== out_lunar_year || want.month !== out_lunar_month ||
            want.day !== out_lunar_day || want.oor !== out_out_of_range) begin
          n_mismatches++;
          $display("%0t: mismatch, expected %0d/%0d/%0d oor=%0b, actual %0d/%0d/%0d oor=%0b",
                   $time, want.year, want.month, want.day, want.oor, out_lunar_year,
                   out_lunar_month, out_lunar_day, out_out_of_range);
        end
      end
    end
  end

  initial begin
    int unsigned sel, yr, mo, dy, idle;
    add_date(1901, 1, 1, 0);
    add_date(1901, 2, 18, 0);
    add_date(1901, 2, 19, 3);
    add_date(1902, 1, 15, 0);
    add_date(1903, 7, 10, 9);
    add_date(1903, 12, 31, 0);
    add_date(1917, 1, 22, 1);
    add_date(1917, 1, 23, 0);
    add_date(2000, 2, 29, 0);
    add_date(2000, 3, 1, 5);
    add_date(2001, 2, 31, 0);
    add_date(2099, 12, 31, 0);
    add_date(2098, 12, 31, 2);
    add_date(2100, 1, 1, 0);
    add_date(1900, 12, 31, 0);
    add_date(0, 0, 0, 0);
    add_date(4095, 15, 31, 7);
    add_date(1950, 0, 10, 0);
    add_date(1950, 13, 10, 0);
    add_date(1950, 15, 10, 4);
    add_date(1950, 6, 0, 0);
    add_date(1999, 1, 31, 0);
    add_date(2023, 4, 20, 0);
    add_date(2057, 11, 30, 8);
    for (int i = 0; i < RANDOM_DATES; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        yr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095) : $urandom_range(1901, 2099);
        mo = $urandom_range(0, 15);
        dy = $urandom_range(0, 31);
      end else begin
        if (sel < 20) begin
          yr = ($urandom_range(0, 1) == 0) ? $urandom_range(1901, 1903)
                                           : $urandom_range(2097, 2099);
        end else begin
          yr = $urandom_range(1901, 2099);
        end
        mo = (sel < 45) ? $urandom_range(1, 2) : $urandom_range(1, 12);
        dy = $urandom_range(1, 31);
      end
      idle = ((i / 50) % 4 == 3) ? 0 : $urandom_range(0, 9);
      add_date(yr, mo, dy, idle);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (n_dates_sent < n_dates_total) @(posedge clk);
    while (lunar_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
